// File: design/vpw_pkg.sv
// vpw_pkg: shared types, constants and fixed-point helpers of the vertex projection unit
// depends on nothing; imported by every module of the unit
package vpw_pkg;

  // word format
  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * WORD_WIDTH;

  // divider geometry
  localparam int QUO_W      = WORD_WIDTH + FRAC_BITS;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BPS;
  localparam int DIV_LAT    = DIV_STAGES + 2;

  // item queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // field widths
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 4;
  localparam int ORIGIN_W = 14;
  localparam int SIZE_W   = 15;
  localparam int CFG_IDX_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_MODEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_PROJ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROJECT    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t ONE      = word_t'(1) <<< FRAC_BITS;

  // one queued item; x holds the coefficient for loads
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    word_t            x;
    word_t            y;
    word_t            z;
  } item_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
  } view_cfg_t;

  // tag riding along the transform stages
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    word_t            coef;
  } load_tag_t;

  // tag riding along the divide and viewport stages
  typedef struct packed {
    logic valid;
    logic wzero;
  } pt_tag_t;

  // queue head status toward the back part
  typedef struct packed {
    logic  head_valid;
    item_t head;
  } q_head_t;

  // clamp a wide signed value to the word
  function automatic word_t sat_wide(prod_t v);
    word_t r;
    if (v > prod_t'(WORD_MAX)) r = WORD_MAX;
    else if (v < prod_t'(WORD_MIN)) r = WORD_MIN;
    else r = word_t'(v);
    return r;
  endfunction

  // arithmetic shift right, rounding ties away from zero
  function automatic prod_t rnd_shr(prod_t p, int sh);
    prod_t h;
    h = prod_t'(1) <<< (sh - 1);
    if (p < 0) h = h - prod_t'(1);
    return (p + h) >>> sh;
  endfunction

  // saturating add
  function automatic word_t sadd(word_t a, word_t b);
    logic signed [WORD_WIDTH:0] s;
    word_t r;
    s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) r = s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
    else r = word_t'(s);
    return r;
  endfunction

endpackage

// File: design/vpw_front.sv
// vpw_front: accepts items, drops unused commands, queues the rest for the back part
// depends on vpw_pkg
module vpw_front import vpw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  input  logic    pop,
  output q_head_t qh
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push;

  // classify: only known commands enter the queue
  assign in_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push = in_valid && in_ready &&
                (in_item.cmd inside {CMD_LOAD_MODEL, CMD_LOAD_PROJ, CMD_PROJECT});

  assign qh.head_valid = (count != '0);
  assign qh.head       = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// File: design/vpw_xform.sv
// vpw_xform: 4x4 column-major matrix times vector, three register stages
// depends on vpw_pkg
module vpw_xform import vpw_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t mat [16],
  input  word_t vec [4],
  output word_t res [4]
);

  prod_t prod [16];
  word_t term [16];

  // products, one per coefficient
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          prod[c*4+r] <= prod_t'(mat[c*4+r]) * prod_t'(vec[c]);
        end
      end
    end
  end

  // round back to the word
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 16; i++) begin
        term[i] <= sat_wide(rnd_shr(prod[i], FRAC_BITS));
      end
    end
  end

  // row sums in column order, saturating after each add
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        res[r] <= sadd(sadd(sadd(term[r], term[4+r]), term[8+r]), term[12+r]);
      end
    end
  end

endmodule

// File: design/vpw_div.sv
// vpw_div: pipelined restoring divider, round(n * 2^FRAC_BITS / d), saturated
// depends on vpw_pkg
module vpw_div import vpw_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t num_in,
  input  word_t den_in,
  output word_t quo_out
);

  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (WORD_WIDTH - 1);
  localparam logic [QUO_W-1:0] POS_LIM = NEG_LIM - 1'b1;

  logic [QUO_W-1:0]      num [DIV_STAGES+1];
  logic [QUO_W-1:0]      quo [DIV_STAGES+1];
  logic [WORD_WIDTH-1:0] rem [DIV_STAGES+1];
  logic [WORD_WIDTH-1:0] den [DIV_STAGES+1];
  logic                  neg [DIV_STAGES+1];

  logic [WORD_WIDTH-1:0] mag_n;
  logic [WORD_WIDTH-1:0] mag_d;
  logic                  rnd;
  logic [QUO_W-1:0]      qr;

  // magnitudes and sign
  assign mag_n = num_in[WORD_WIDTH-1] ? WORD_WIDTH'(-num_in) : WORD_WIDTH'(num_in);
  assign mag_d = den_in[WORD_WIDTH-1] ? WORD_WIDTH'(-den_in) : WORD_WIDTH'(den_in);

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= num_in[WORD_WIDTH-1] ^ den_in[WORD_WIDTH-1];
      num[0] <= {mag_n, {FRAC_BITS{1'b0}}};
      den[0] <= mag_d;
      quo[0] <= '0;
      rem[0] <= '0;
    end
  end

  // quotient bits, DIV_BPS per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [QUO_W-1:0]      n_nx;
    logic [QUO_W-1:0]      q_nx;
    logic [WORD_WIDTH-1:0] r_nx;

    always_comb begin
      logic [WORD_WIDTH:0] r2;
      n_nx = num[k];
      q_nx = quo[k];
      r_nx = rem[k];
      for (int b = 0; b < DIV_BPS; b++) begin
        r2   = {r_nx, n_nx[QUO_W-1]};
        n_nx = n_nx << 1;
        q_nx = q_nx << 1;
        if (r2 >= {1'b0, den[k]}) begin
          r2      = r2 - {1'b0, den[k]};
          q_nx[0] = 1'b1;
        end
        r_nx = r2[WORD_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= n_nx;
        quo[k+1] <= q_nx;
        rem[k+1] <= r_nx;
        den[k+1] <= den[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  // round half away from zero, then clamp to the word
  assign rnd = ({rem[DIV_STAGES], 1'b0} >= {1'b0, den[DIV_STAGES]});
  assign qr  = quo[DIV_STAGES] + QUO_W'(rnd);

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[DIV_STAGES]) begin
        quo_out <= (qr >= NEG_LIM) ? WORD_MIN : word_t'(-qr[WORD_WIDTH-1:0]);
      end else begin
        quo_out <= (qr > POS_LIM) ? WORD_MAX : word_t'(qr[WORD_WIDTH-1:0]);
      end
    end
  end

endmodule

// File: design/vpw_back.sv
// vpw_back: matrices, two transforms, divide by w and viewport mapping, output register
// depends on vpw_pkg, vpw_xform, vpw_div
module vpw_back import vpw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   qh,
  output logic      pop,
  input  view_cfg_t cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output word_t     win_x,
  output word_t     win_y,
  output word_t     win_z,
  output logic      proj_ok
);

  localparam int XF_TAGS = 3;

  logic      adv;
  word_t     model_m [16];
  word_t     proj_m  [16];
  word_t     vec_m   [4];
  word_t     eye     [4];
  word_t     clip    [4];
  load_tag_t sm      [XF_TAGS];
  logic      sp_vld  [XF_TAGS];
  pt_tag_t   sd      [DIV_LAT];
  word_t     nx, ny, nz;
  pt_tag_t   v1, v2;
  word_t     tx, ty, tz, tz2;
  prod_t     px, py;
  word_t     ox_w, oy_w;

  // whole back pipeline moves together when the output can take a new item
  assign adv = !out_valid || out_ready;
  assign pop = adv && qh.head_valid;

  // model matrix is written as its load leaves the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) model_m[i] <= '0;
    end else if (pop && qh.head.cmd == CMD_LOAD_MODEL) begin
      model_m[qh.head.idx] <= qh.head.x;
    end
  end

  assign vec_m[0] = qh.head.x;
  assign vec_m[1] = qh.head.y;
  assign vec_m[2] = qh.head.z;
  assign vec_m[3] = ONE;

  vpw_xform u_model (.clk(clk), .en(adv), .mat(model_m), .vec(vec_m), .res(eye));

  // tags alongside the model transform
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < XF_TAGS; i++) sm[i] <= '0;
    end else if (adv) begin
      sm[0] <= '{valid: pop, cmd: qh.head.cmd, idx: qh.head.idx, coef: qh.head.x};
      for (int i = 1; i < XF_TAGS; i++) sm[i] <= sm[i-1];
    end
  end

  // projection matrix is written where the projection transform reads it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) proj_m[i] <= '0;
    end else if (adv && sm[XF_TAGS-1].valid && sm[XF_TAGS-1].cmd == CMD_LOAD_PROJ) begin
      proj_m[sm[XF_TAGS-1].idx] <= sm[XF_TAGS-1].coef;
    end
  end

  vpw_xform u_proj (.clk(clk), .en(adv), .mat(proj_m), .vec(eye), .res(clip));

  // tags alongside the projection transform
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < XF_TAGS; i++) sp_vld[i] <= 1'b0;
    end else if (adv) begin
      sp_vld[0] <= sm[XF_TAGS-1].valid && sm[XF_TAGS-1].cmd == CMD_PROJECT;
      for (int i = 1; i < XF_TAGS; i++) sp_vld[i] <= sp_vld[i-1];
    end
  end

  // perspective divide
  vpw_div u_div_x (.clk(clk), .en(adv), .num_in(clip[0]), .den_in(clip[3]), .quo_out(nx));
  vpw_div u_div_y (.clk(clk), .en(adv), .num_in(clip[1]), .den_in(clip[3]), .quo_out(ny));
  vpw_div u_div_z (.clk(clk), .en(adv), .num_in(clip[2]), .den_in(clip[3]), .quo_out(nz));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) sd[i] <= '0;
    end else if (adv) begin
      sd[0] <= '{valid: sp_vld[XF_TAGS-1], wzero: (clip[3] == '0)};
      for (int i = 1; i < DIV_LAT; i++) sd[i] <= sd[i-1];
    end
  end

  // viewport: shift to [0, 2]
  always_ff @(posedge clk) begin
    if (adv) begin
      tx <= sadd(ONE, nx);
      ty <= sadd(ONE, ny);
      tz <= sadd(ONE, nz);
    end
  end

  // viewport: scale by size
  always_ff @(posedge clk) begin
    if (adv) begin
      px  <= prod_t'(tx) * prod_t'(cfg.width);
      py  <= prod_t'(ty) * prod_t'(cfg.height);
      tz2 <= tz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
      v2 <= '0;
    end else if (adv) begin
      v1 <= sd[DIV_LAT-1];
      v2 <= v1;
    end
  end

  assign ox_w = word_t'(cfg.origin_x) <<< FRAC_BITS;
  assign oy_w = word_t'(cfg.origin_y) <<< FRAC_BITS;

  // output register: halve, add origin
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      proj_ok <= !v2.wzero;
      if (v2.wzero) begin
        win_x <= '0;
        win_y <= '0;
        win_z <= '0;
      end else begin
        win_x <= sadd(ox_w, sat_wide(rnd_shr(px, 1)));
        win_y <= sadd(oy_w, sat_wide(rnd_shr(py, 1)));
        win_z <= sat_wide(rnd_shr(prod_t'(tz2), 1));
      end
    end
  end

  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    out_valid && !proj_ok |-> win_x == '0 && win_y == '0 && win_z == '0)
    else $error("zero w item carries nonzero coordinates");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> qh.head_valid)
    else $error("pop from an empty queue");

endmodule

// File: design/vertex_project_to_window_unit.sv
// vertex_project_to_window_unit: top level, ports, configuration registers
// depends on vpw_pkg, vpw_front, vpw_back
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    tuser command, tdata index, coefficient, point
// m_*      out  m_tvalid / m_tready    tuser proj_ok, tdata window x, y, z
// cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data (viewport registers)
//
// one item per cycle sustained while the output is not stalled; a point passes from queue
// head through two 3-stage matrix transforms, the 24-stage divider and the viewport stages
// reset is synchronous; matrices and viewport registers clear to zero
// a stalled output holds the back pipeline; the 4-entry queue keeps taking items until full
// configuration writes are always ready
module vertex_project_to_window_unit import vpw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [135:0]          s_tdata,   // coef_index, coef_value, obj_x, obj_y, obj_z, pad
  input  logic [CMD_W-1:0]      s_tuser,   // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [95:0]           m_tdata,   // win_x, win_y, win_z
  output logic                  m_tuser,   // proj_ok
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  item_t     in_item;
  q_head_t   qh;
  logic      pop;
  view_cfg_t cfg;
  word_t     win_x, win_y, win_z;

  // unpack the input item; loads carry the coefficient in the x slot
  assign in_item.cmd = s_tuser;
  assign in_item.idx = s_tdata[3:0];
  assign in_item.x   = (s_tuser == CMD_PROJECT) ? word_t'(s_tdata[67:36])
                                                : word_t'(s_tdata[35:4]);
  assign in_item.y   = word_t'(s_tdata[99:68]);
  assign in_item.z   = word_t'(s_tdata[131:100]);

  // viewport registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: cfg.origin_x <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_Y: cfg.origin_y <= cfg_data[ORIGIN_W-1:0];
        REG_WIDTH:    cfg.width    <= cfg_data;
        REG_HEIGHT:   cfg.height   <= cfg_data;
        default: ;
      endcase
    end
  end

  vpw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .pop      (pop),
    .qh       (qh)
  );

  vpw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qh        (qh),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .win_x     (win_x),
    .win_y     (win_y),
    .win_z     (win_z),
    .proj_ok   (m_tuser)
  );

  assign m_tdata = {win_z, win_y, win_x};

endmodule
